/* rtl/evpc_pkg.sv */
package evpc_pkg;

    // field and register widths
    localparam int BASE_W    = 12;
    localparam int CLIP_W    = 4;
    localparam int DIM_W     = 10;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 9;
    localparam int TOTAL_W   = 50;
    localparam int SUM_W     = TOTAL_W + 1;
    localparam int NUM_W     = BASE_W + SUM_W;
    localparam int PIX_W     = 2 * DIM_W;
    localparam int PIX2_W    = PIX_W + 1;
    localparam int LIM_W     = 16;
    localparam int THR_W     = 16;
    localparam int OFF_W     = 17;
    localparam int EVT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // register reset values
    localparam logic [BASE_W-1:0] BASE_RST   = 12'd410;
    localparam logic [CLIP_W-1:0] CLIP_RST   = 4'd5;
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 10'd346;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 10'd260;

    // item kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_MUL,
        ST_DIV_PIX,
        ST_DIV_ON,
        ST_DIV_OFF,
        ST_DONE
    } state_t;

endpackage

/* rtl/event_pixel_contrast_calibrator_top.sv */
// Channel   Direction  Handshake            Payload
// in        slave      in_valid / in_stall  kind, col, row, polarity
// out       master     out_valid/ out_stall on/off threshold, clip flags, counts, total
// cfg       slave      cfg_we               cfg_index, cfg_data (no read-back)
//
// Event item: accept, then read-modify-write of one count memory port.
// Read item: three 63-step restoring divisions on one shared subtract/compare unit
//   (base*total / (2*pixels), then that quotient by the ON and by the OFF count).
// Reset: a clearing pass writes zero to every count entry (MAX_COLS*MAX_ROWS entries,
//   262144 at defaults); in_stall is high meanwhile, cfg writes are taken.
// A finished result sits in the output register; a new item is taken while it waits.
module event_pixel_contrast_calibrator_top #(
    parameter int MAX_COLS   = 512,
    parameter int MAX_ROWS   = 512,
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [evpc_pkg::COL_W-1:0]          col,
    input  logic [evpc_pkg::ROW_W-1:0]          row,
    input  logic                                polarity,
    // result items
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [evpc_pkg::THR_W-1:0]          on_threshold,
    output logic signed [evpc_pkg::OFF_W-1:0]   off_threshold,
    output logic                                on_clipped,
    output logic                                off_clipped,
    output logic [evpc_pkg::EVT_W-1:0]          on_events,
    output logic [evpc_pkg::EVT_W-1:0]          off_events,
    output logic [evpc_pkg::TOTAL_W-1:0]        total_events,
    // configuration
    input  logic                                cfg_we,
    input  logic [evpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [evpc_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    // divisor is either 2*pixels or an ON or OFF pixel count
    localparam int DV_W   = COUNT_BITS > evpc_pkg::PIX2_W ? COUNT_BITS : evpc_pkg::PIX2_W;
    localparam int STEP_W = $clog2(evpc_pkg::NUM_W);
    localparam int NUM_W  = evpc_pkg::NUM_W;

    // ---------------- control registers ----------------
    evpc_pkg::state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]                 clr_addr_reg, clr_addr_next;
    logic                              out_valid_reg, out_valid_next;
    logic [evpc_pkg::BASE_W-1:0]       base_reg, base_next;
    logic [evpc_pkg::CLIP_W-1:0]       clip_reg, clip_next;
    logic [evpc_pkg::DIM_W-1:0]        width_reg, width_next;
    logic [evpc_pkg::DIM_W-1:0]        height_reg, height_next;
    logic [evpc_pkg::TOTAL_W-1:0]      on_total_reg, on_total_next;
    logic [evpc_pkg::TOTAL_W-1:0]      off_total_reg, off_total_next;
    logic [STEP_W-1:0]                 step_reg, step_next;

    // ---------------- item / datapath registers ----------------
    logic                              kind_reg, kind_next;
    logic                              pol_reg, pol_next;
    logic                              inside_reg, inside_next;
    logic [ADDR_W-1:0]                 addr_reg, addr_next;
    logic [COUNT_BITS-1:0]             on_cnt_reg, on_cnt_next;
    logic [COUNT_BITS-1:0]             off_cnt_reg, off_cnt_next;
    logic [evpc_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [evpc_pkg::PIX2_W-1:0]       pix2_reg, pix2_next;
    logic                              pix_zero_reg, pix_zero_next;
    logic [NUM_W-1:0]                  num_reg, num_next;     // dividend, becomes quotient
    logic [DV_W-1:0]                   rem_reg, rem_next;
    logic [NUM_W-1:0]                  q1_reg, q1_next;       // base*total / (2*pixels)
    logic [NUM_W-1:0]                  onq_reg, onq_next;

    logic [evpc_pkg::THR_W-1:0]        on_thr_reg, on_thr_next;
    logic [evpc_pkg::OFF_W-1:0]        off_thr_reg, off_thr_next;
    logic                              on_clip_reg, on_clip_next;
    logic                              off_clip_reg, off_clip_next;
    logic [evpc_pkg::EVT_W-1:0]        on_evt_reg, on_evt_next;
    logic [evpc_pkg::EVT_W-1:0]        off_evt_reg, off_evt_next;
    logic [evpc_pkg::TOTAL_W-1:0]      tot_evt_reg, tot_evt_next;

    // ---------------- count memories ----------------
    logic                              on_we, off_we;
    logic [ADDR_W-1:0]                 ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0]             on_wdata, off_wdata;
    logic [COUNT_BITS-1:0]             on_rdata, off_rdata;

    evpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_on_ram (
        .clk   (clk),
        .we    (on_we),
        .waddr (ram_waddr),
        .wdata (on_wdata),
        .raddr (ram_raddr),
        .rdata (on_rdata)
    );

    evpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (ram_waddr),
        .wdata (off_wdata),
        .raddr (ram_raddr),
        .rdata (off_rdata)
    );

    // ---------------- input decode ----------------
    logic                  in_acc;
    logic                  acc_inside;
    logic [ADDR_W-1:0]     acc_addr;

    assign in_stall = (state_reg != evpc_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        acc_inside = ({1'b0, col} < width_reg) && ({1'b0, row} < height_reg)
                  && (32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);
        acc_addr   = acc_inside ? ADDR_W'(32'(row) * 32'(MAX_COLS) + 32'(col)) : '0;
    end

    // read port follows the input; data lands while in ST_LOOK
    assign ram_raddr = acc_addr;

    // ---------------- shared arithmetic ----------------
    logic [DV_W-1:0]                 divisor;
    logic [DV_W:0]                   rem_sh;
    logic [DV_W:0]                   rem_diff;
    logic                            q_bit;
    logic [NUM_W-1:0]                num_step;
    logic [DV_W-1:0]                 rem_step;
    logic                            last_step;
    logic [NUM_W-1:0]                product;
    logic [evpc_pkg::PIX_W-1:0]      pix;
    logic [evpc_pkg::LIM_W-1:0]      limit;
    logic                            on_clip_c, off_clip_c;
    logic [evpc_pkg::THR_W-1:0]      on_mag, off_mag;
    logic [63:0]                     on_cnt_ext, off_cnt_ext;
    logic [COUNT_BITS-1:0]           cnt_inc_on, cnt_inc_off;

    always_comb
    begin
        unique case (state_reg)
            evpc_pkg::ST_DIV_ON:  divisor = DV_W'(on_cnt_reg);
            evpc_pkg::ST_DIV_OFF: divisor = DV_W'(off_cnt_reg);
            default:              divisor = DV_W'(pix2_reg);
        endcase
        // one restoring step: a zero divisor gives junk that the clip flags override
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        rem_diff  = rem_sh - {1'b0, divisor};
        q_bit     = (rem_sh >= {1'b0, divisor});
        rem_step  = q_bit ? rem_diff[DV_W-1:0] : rem_sh[DV_W-1:0];
        num_step  = {num_reg[NUM_W-2:0], q_bit};
        last_step = (step_reg == STEP_W'(NUM_W - 1));

        product = {{evpc_pkg::SUM_W{1'b0}}, base_reg} * {{evpc_pkg::BASE_W{1'b0}}, sum_reg};
        pix     = {{evpc_pkg::DIM_W{1'b0}}, width_reg} * {{evpc_pkg::DIM_W{1'b0}}, height_reg};
        limit   = evpc_pkg::LIM_W'(base_reg) * evpc_pkg::LIM_W'(clip_reg);

        on_clip_c  = pix_zero_reg || (on_cnt_reg == '0) || (onq_reg > NUM_W'(limit));
        off_clip_c = pix_zero_reg || (off_cnt_reg == '0) || (num_reg > NUM_W'(limit));
        on_mag     = on_clip_c ? limit : onq_reg[evpc_pkg::THR_W-1:0];
        off_mag    = off_clip_c ? limit : num_reg[evpc_pkg::THR_W-1:0];

        on_cnt_ext  = 64'(on_cnt_reg);
        off_cnt_ext = 64'(off_cnt_reg);

        // saturating count updates
        cnt_inc_on  = (on_rdata == '1) ? on_rdata : on_rdata + 1'b1;
        cnt_inc_off = (off_rdata == '1) ? off_rdata : off_rdata + 1'b1;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        base_next      = base_reg;
        clip_next      = clip_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        on_total_next  = on_total_reg;
        off_total_next = off_total_reg;
        step_next      = step_reg;

        kind_next      = kind_reg;
        pol_next       = pol_reg;
        inside_next    = inside_reg;
        addr_next      = addr_reg;
        on_cnt_next    = on_cnt_reg;
        off_cnt_next   = off_cnt_reg;
        sum_next       = sum_reg;
        pix2_next      = pix2_reg;
        pix_zero_next  = pix_zero_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q1_next        = q1_reg;
        onq_next       = onq_reg;
        on_thr_next    = on_thr_reg;
        off_thr_next   = off_thr_reg;
        on_clip_next   = on_clip_reg;
        off_clip_next  = off_clip_reg;
        on_evt_next    = on_evt_reg;
        off_evt_next   = off_evt_reg;
        tot_evt_next   = tot_evt_reg;

        on_we     = 1'b0;
        off_we    = 1'b0;
        ram_waddr = addr_reg;
        on_wdata  = cnt_inc_on;
        off_wdata = cnt_inc_off;

        if (cfg_we)
        begin
            unique case (cfg_index)
                evpc_pkg::REG_BASE:   base_next   = cfg_data;
                evpc_pkg::REG_CLIP:   clip_next   = cfg_data[evpc_pkg::CLIP_W-1:0];
                evpc_pkg::REG_WIDTH:  width_next  = cfg_data[evpc_pkg::DIM_W-1:0];
                evpc_pkg::REG_HEIGHT: height_next = cfg_data[evpc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            evpc_pkg::ST_CLEAR:
            begin
                on_we         = 1'b1;
                off_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                on_wdata      = '0;
                off_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = evpc_pkg::ST_IDLE;
                end
            end

            evpc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next   = kind;
                    pol_next    = polarity;
                    inside_next = acc_inside;
                    addr_next   = acc_addr;
                    state_next  = evpc_pkg::ST_LOOK;
                end
            end

            evpc_pkg::ST_LOOK:
            begin
                if (kind_reg == evpc_pkg::KIND_EVENT)
                begin
                    if (inside_reg)
                    begin
                        if (pol_reg)
                        begin
                            on_we = 1'b1;
                            if (on_total_reg != '1)
                            begin
                                on_total_next = on_total_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            off_we = 1'b1;
                            if (off_total_reg != '1)
                            begin
                                off_total_next = off_total_reg + 1'b1;
                            end
                        end
                    end
                    state_next = evpc_pkg::ST_IDLE;
                end
                else
                begin
                    on_cnt_next   = inside_reg ? on_rdata : '0;
                    off_cnt_next  = inside_reg ? off_rdata : '0;
                    sum_next      = {1'b0, on_total_reg} + {1'b0, off_total_reg};
                    pix2_next     = {pix, 1'b0};
                    pix_zero_next = (pix == '0);
                    state_next    = evpc_pkg::ST_MUL;
                end
            end

            evpc_pkg::ST_MUL:
            begin
                num_next   = product;
                rem_next   = '0;
                step_next  = '0;
                state_next = evpc_pkg::ST_DIV_PIX;
            end

            evpc_pkg::ST_DIV_PIX, evpc_pkg::ST_DIV_ON, evpc_pkg::ST_DIV_OFF:
            begin
                num_next  = num_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    rem_next  = '0;
                    step_next = '0;
                    if (state_reg == evpc_pkg::ST_DIV_PIX)
                    begin
                        q1_next    = num_step;
                        state_next = evpc_pkg::ST_DIV_ON;
                    end
                    else if (state_reg == evpc_pkg::ST_DIV_ON)
                    begin
                        onq_next   = num_step;
                        num_next   = q1_reg;
                        state_next = evpc_pkg::ST_DIV_OFF;
                    end
                    else
                    begin
                        state_next = evpc_pkg::ST_DONE;
                    end
                end
            end

            evpc_pkg::ST_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    on_thr_next    = on_mag;
                    off_thr_next   = evpc_pkg::OFF_W'(0) - {1'b0, off_mag};
                    on_clip_next   = on_clip_c;
                    off_clip_next  = off_clip_c;
                    on_evt_next    = (on_cnt_ext > 64'hFFFF_FFFF) ? '1 : on_cnt_ext[31:0];
                    off_evt_next   = (off_cnt_ext > 64'hFFFF_FFFF) ? '1 : off_cnt_ext[31:0];
                    tot_evt_next   = sum_reg[evpc_pkg::SUM_W-1] ? '1
                                   : sum_reg[evpc_pkg::TOTAL_W-1:0];
                    state_next     = evpc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = evpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evpc_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= evpc_pkg::BASE_RST;
            clip_reg      <= evpc_pkg::CLIP_RST;
            width_reg     <= evpc_pkg::WIDTH_RST;
            height_reg    <= evpc_pkg::HEIGHT_RST;
            on_total_reg  <= '0;
            off_total_reg <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            clip_reg      <= clip_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            on_total_reg  <= on_total_next;
            off_total_reg <= off_total_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pol_reg      <= pol_next;
        inside_reg   <= inside_next;
        addr_reg     <= addr_next;
        on_cnt_reg   <= on_cnt_next;
        off_cnt_reg  <= off_cnt_next;
        sum_reg      <= sum_next;
        pix2_reg     <= pix2_next;
        pix_zero_reg <= pix_zero_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        q1_reg       <= q1_next;
        onq_reg      <= onq_next;
        on_thr_reg   <= on_thr_next;
        off_thr_reg  <= off_thr_next;
        on_clip_reg  <= on_clip_next;
        off_clip_reg <= off_clip_next;
        on_evt_reg   <= on_evt_next;
        off_evt_reg  <= off_evt_next;
        tot_evt_reg  <= tot_evt_next;
    end

    assign out_valid     = out_valid_reg;
    assign on_threshold  = on_thr_reg;
    assign off_threshold = off_thr_reg;
    assign on_clipped    = on_clip_reg;
    assign off_clipped   = off_clip_reg;
    assign on_events     = on_evt_reg;
    assign off_events    = off_evt_reg;
    assign total_events  = tot_evt_reg;

endmodule

/* rtl/evpc_ram.sv */
module evpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/evpc_checker.sv */
module evpc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [evpc_pkg::THR_W-1:0]          on_threshold,
    input  logic signed [evpc_pkg::OFF_W-1:0]   off_threshold,
    input  logic                                on_clipped,
    input  logic [evpc_pkg::EVT_W-1:0]          on_events
);

    // stalled item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(on_threshold))
        else $error("output item dropped or changed under stall");

    // OFF threshold is never positive
    a_off_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (off_threshold == '0) || off_threshold[evpc_pkg::OFF_W-1])
        else $error("positive OFF threshold");

    // an unclipped ON threshold needs a nonzero ON count
    a_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !on_clipped |-> on_events != '0)
        else $error("unclipped ON threshold with zero count");

endmodule

bind event_pixel_contrast_calibrator_top evpc_checker u_evpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .on_threshold  (on_threshold),
    .off_threshold (off_threshold),
    .on_clipped    (on_clipped),
    .on_events     (on_events)
);
